/* rtl/core/wsdf_pkg.sv */
`timescale 1ns / 1ps

package wsdf_pkg;

    // Width of the payload length counter. 64 covers every RFC 6455 length.
    localparam int LENGTH_BITS = 64;

    localparam logic [3:0] OPCODE_TEXT  = 4'h1;
    localparam logic [3:0] OPCODE_CLOSE = 4'h8;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_CLOSE   = 2'd2;

    // One parser result, handed from the parser to the output register.
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } wsdf_result_t;

endpackage

/* rtl/core/wsdf_parser.sv */
`timescale 1ns / 1ps

module wsdf_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    input  logic                  link_down,
    output wsdf_pkg::wsdf_result_t result,
    output logic                  closed
);
    import wsdf_pkg::*;

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_MASK = 3'd3;
    localparam logic [2:0] PH_TEXT = 3'd4;
    localparam logic [2:0] PH_SKIP = 3'd5;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    logic [2:0]             phase_reg, phase_next;
    logic [3:0]             count_reg, count_next;
    logic [3:0]             opcode_reg, opcode_next;
    logic                   masked_reg, masked_next;
    logic [LENGTH_BITS-1:0] remaining_reg, remaining_next;
    logic [31:0]            key_reg, key_next;
    logic [1:0]             pos_reg, pos_next;
    logic                   closed_reg, closed_next;

    logic       header_done;
    logic [7:0] key_byte;

    always_comb begin
        case (pos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        opcode_next    = opcode_reg;
        masked_next    = masked_reg;
        remaining_next = remaining_reg;
        key_next       = key_reg;
        pos_next       = pos_reg;
        closed_next    = closed_reg;
        header_done    = 1'b0;
        result         = '0;

        if (step && !closed_reg) begin
            if (link_down) begin
                closed_next = 1'b1;
                result      = '{valid: 1'b1, kind: KIND_CLOSE, data: 8'h00, last: 1'b1};
            end else begin
                unique case (phase_reg)
                    PH_HDR0: begin
                        opcode_next = data_byte[3:0];
                        phase_next  = PH_HDR1;
                    end
                    PH_HDR1: begin
                        if (opcode_reg == OPCODE_CLOSE) begin
                            closed_next = 1'b1;
                            result      = '{valid: 1'b1, kind: KIND_CLOSE,
                                           data: 8'h00, last: 1'b1};
                        end else begin
                            masked_next    = data_byte[7];
                            key_next       = '0;
                            remaining_next = '0;
                            if (data_byte[6:0] == LEN7_EXT16) begin
                                phase_next = PH_EXT;
                                count_next = 4'd2;
                            end else if (data_byte[6:0] == LEN7_EXT64) begin
                                phase_next = PH_EXT;
                                count_next = 4'd8;
                            end else begin
                                remaining_next = {{(LENGTH_BITS-7){1'b0}}, data_byte[6:0]};
                                if (data_byte[7]) begin
                                    phase_next = PH_MASK;
                                    count_next = 4'd4;
                                end else begin
                                    header_done = 1'b1;
                                end
                            end
                        end
                    end
                    PH_EXT: begin
                        // A length that would overflow the counter saturates.
                        if (|remaining_reg[LENGTH_BITS-1 -: 8]) begin
                            remaining_next = '1;
                        end else begin
                            remaining_next = {remaining_reg[LENGTH_BITS-9:0], data_byte};
                        end
                        count_next = count_reg - 4'd1;
                        if (count_reg == 4'd1) begin
                            if (masked_reg) begin
                                phase_next = PH_MASK;
                                count_next = 4'd4;
                            end else begin
                                header_done = 1'b1;
                            end
                        end
                    end
                    PH_MASK: begin
                        key_next   = {key_reg[23:0], data_byte};
                        count_next = count_reg - 4'd1;
                        if (count_reg == 4'd1) begin
                            header_done = 1'b1;
                        end
                    end
                    PH_TEXT: begin
                        pos_next       = pos_reg + 2'd1;
                        remaining_next = remaining_reg - LENGTH_BITS'(1);
                        result.valid   = 1'b1;
                        result.kind    = KIND_PAYLOAD;
                        result.data    = masked_reg ? (data_byte ^ key_byte) : data_byte;
                        result.last    = (remaining_reg == {{(LENGTH_BITS-1){1'b0}}, 1'b1});
                        if (result.last) begin
                            phase_next = PH_HDR0;
                        end
                    end
                    PH_SKIP: begin
                        remaining_next = remaining_reg - LENGTH_BITS'(1);
                        if (remaining_reg == {{(LENGTH_BITS-1){1'b0}}, 1'b1}) begin
                            phase_next = PH_HDR0;
                        end
                    end
                    default: begin
                        phase_next = PH_HDR0;
                    end
                endcase

                // Header finished: pick the payload handling for this frame.
                if (header_done) begin
                    pos_next = 2'd0;
                    if (remaining_next == '0) begin
                        phase_next = PH_HDR0;
                        if (opcode_reg == OPCODE_TEXT) begin
                            result = '{valid: 1'b1, kind: KIND_EMPTY, data: 8'h00, last: 1'b1};
                        end
                    end else begin
                        phase_next = (opcode_reg == OPCODE_TEXT) ? PH_TEXT : PH_SKIP;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HDR0;
            count_reg     <= '0;
            opcode_reg    <= '0;
            masked_reg    <= 1'b0;
            remaining_reg <= '0;
            key_reg       <= '0;
            pos_reg       <= '0;
            closed_reg    <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            opcode_reg    <= opcode_next;
            masked_reg    <= masked_next;
            remaining_reg <= remaining_next;
            key_reg       <= key_next;
            pos_reg       <= pos_next;
            closed_reg    <= closed_next;
        end
    end

    assign closed = closed_reg;

endmodule

/* rtl/core/ws_frame_deframer_unmasker_top.sv */
`timescale 1ns / 1ps

// WebSocket frame deframer and unmasker.
//
// The slave stream carries the received connection bytes, one per beat, with
// s_tuser flagging a lost link. Frames are parsed back to back: header, optional
// extended length, optional mask key, then payload. Text frames produce one
// master beat per payload byte, unmasked, with m_tlast on the final byte; a
// zero-length text frame produces one empty-message beat instead. A close frame
// (reported on its second header byte) or a lost link produces one close beat,
// after which every further input beat is accepted and dropped until reset.
// Payloads of all other opcodes are consumed without output.
//
// An accepted input beat reaches the master side through two registers: the
// input register, then the output register. One byte is taken every cycle as
// long as the master side keeps m_tready high; the parser steps on one byte at
// a time between those two registers.
// When the receiver stalls, the held result blocks the parser, and s_tready
// stays low while the input register holds a beat.
// Reset (aresetn low, synchronous) returns the parser to the first header byte,
// clears the closed flag and empties both registers.
module ws_frame_deframer_unmasker_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] data_byte
    input  logic       s_tuser,    // [0] link_down
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] payload_byte
    output logic [1:0] m_tuser,    // [1:0] event_kind
    output logic       m_tlast     // last_of_message
);
    import wsdf_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_down_reg;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] out_kind_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;

    logic         advance;
    logic         closed;
    wsdf_result_t result;

    // The parser moves when it holds a beat and the output register is free
    // or is being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? result.valid : (out_valid_reg && !m_tready);

    wsdf_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .data_byte (in_byte_reg),
        .link_down (in_down_reg),
        .result    (result),
        .closed    (closed)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_down_reg <= s_tuser;
        end
        if (advance && result.valid) begin
            out_kind_reg <= result.kind;
            out_data_reg <= result.data;
            out_last_reg <= result.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // The input register only waits when the output register is full and stalled.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |-> out_valid_reg && !m_tready)
        else $error("input held without an output stall");

    // Empty-message and close beats always carry last and a zero byte.
    a_event_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != KIND_PAYLOAD) |-> m_tlast && (m_tdata == 8'h00))
        else $error("event beat without last or with nonzero data");

    // Only the three defined event kinds ever leave the block.
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == KIND_PAYLOAD) || (m_tuser == KIND_EMPTY)
                     || (m_tuser == KIND_CLOSE))
        else $error("undefined event kind");

    // Nothing follows a delivered close beat.
    a_silent_after_close: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && (m_tuser == KIND_CLOSE) |=> !m_tvalid && closed)
        else $error("output after close event");

endmodule
